@@ src/prtm_pkg.sv @@
// ----------------------------------------------------------------------------
// prtm_pkg: shared types and constants of the power rail tamper monitor
// Holds the sample and result payload types, register indexes, reason codes
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package prtm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_VOLTAGE_MIN  = 3'd0,
    CFG_VOLTAGE_MAX  = 3'd1,
    CFG_CURRENT_LIM  = 3'd2,
    CFG_VOLTAGE_JUMP = 3'd3,
    CFG_CURRENT_JUMP = 3'd4,
    CFG_FAILURE_LIM  = 3'd5,
    CFG_CHECK_PERIOD = 3'd6,
    CFG_EXPECTED_CFG = 3'd7
  } cfg_idx_e;

  // Reason a sample was rejected
  typedef enum logic [2:0] {
    REASON_NONE         = 3'd0,
    REASON_VOLT_WINDOW  = 3'd1,
    REASON_CURR_RANGE   = 3'd2,
    REASON_VOLT_JUMP    = 3'd3,
    REASON_CURR_JUMP    = 3'd4
  } reason_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [14:0] VoltageMinRst  = 15'd1300;
  localparam logic [14:0] VoltageMaxRst  = 15'd5300;
  localparam logic [14:0] CurrentLimRst  = 15'd32767;
  localparam logic [14:0] VoltageJumpRst = 15'd32767;
  localparam logic [15:0] CurrentJumpRst = 16'hFFFF;
  localparam logic [15:0] FailureLimRst  = 16'd1000;
  localparam logic [15:0] CheckPeriodRst = 16'd100;
  localparam logic [15:0] ExpectedCfgRst = 16'h399F;

  localparam logic [15:0] FailCountMax = 16'hFFFF;

  // One monitor sample
  typedef struct packed {
    logic [15:0]        bus_voltage_reg;
    logic signed [15:0] current_count;
    logic [15:0]        config_readback;
  } sample_t;

  // One result item
  typedef struct packed {
    logic               accepted;
    logic [2:0]         fail_reason;
    logic               config_mismatch;
    logic               tampered;
    logic               lockout;
    logic [15:0]        failure_count;
    logic [31:0]        accepted_reads;
    logic [14:0]        bus_voltage_mv;
    logic signed [15:0] current_out;
  } result_t;

endpackage

@@ src/prtm_if.sv @@
// ----------------------------------------------------------------------------
// prtm channel interfaces
// Valid/ready channels for monitor samples and for result items.
// ----------------------------------------------------------------------------
interface prtm_sample_if;
  logic               valid;
  logic               ready;
  logic [15:0]        bus_voltage_reg;
  logic signed [15:0] current_count;
  logic [15:0]        config_readback;

  modport source (output valid, bus_voltage_reg, current_count, config_readback,
                  input ready);
  modport sink (input valid, bus_voltage_reg, current_count, config_readback,
                output ready);
endinterface

interface prtm_result_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [2:0]         fail_reason;
  logic               config_mismatch;
  logic               tampered;
  logic               lockout;
  logic [15:0]        failure_count;
  logic [31:0]        accepted_reads;
  logic [14:0]        bus_voltage_mv;
  logic signed [15:0] current_out;

  modport source (output valid, accepted, fail_reason, config_mismatch, tampered,
                  lockout, failure_count, accepted_reads, bus_voltage_mv,
                  current_out, input ready);
  modport sink (input valid, accepted, fail_reason, config_mismatch, tampered,
                lockout, failure_count, accepted_reads, bus_voltage_mv,
                current_out, output ready);
endinterface

@@ src/power_rail_tamper_monitor.sv @@
// ----------------------------------------------------------------------------
// power_rail_tamper_monitor
// Checks power-monitor samples one per clock while results are taken. Each
// sample transfer lands in an input register; when the result register can
// load, a single pass of compare and subtract logic validates it against the
// window, range and jump limits, updates the tamper, safe-mode, failure and
// read state, and loads the result register. A new sample is taken every
// cycle while the result side keeps up, so the sustained rate is one item per
// clock; the state update in the check stage, done in a single pass, is what
// sets that rate. Configuration registers are written through the plain write
// port and must only change while idle.
// ----------------------------------------------------------------------------
module power_rail_tamper_monitor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prtm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [prtm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  prtm_sample_if.sink                       sample_i,
  prtm_result_if.source                     result_o
);

  // Configuration registers
  logic [14:0] volt_min_q, volt_max_q, curr_lim_q, volt_jump_q;
  logic [15:0] curr_jump_q, fail_lim_q, period_q, exp_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_min_q  <= prtm_pkg::VoltageMinRst;
      volt_max_q  <= prtm_pkg::VoltageMaxRst;
      curr_lim_q  <= prtm_pkg::CurrentLimRst;
      volt_jump_q <= prtm_pkg::VoltageJumpRst;
      curr_jump_q <= prtm_pkg::CurrentJumpRst;
      fail_lim_q  <= prtm_pkg::FailureLimRst;
      period_q    <= prtm_pkg::CheckPeriodRst;
      exp_cfg_q   <= prtm_pkg::ExpectedCfgRst;
    end else if (cfg_we_i) begin
      case (prtm_pkg::cfg_idx_e'(cfg_idx_i))
        prtm_pkg::CFG_VOLTAGE_MIN:  volt_min_q  <= cfg_wdata_i[14:0];
        prtm_pkg::CFG_VOLTAGE_MAX:  volt_max_q  <= cfg_wdata_i[14:0];
        prtm_pkg::CFG_CURRENT_LIM:  curr_lim_q  <= cfg_wdata_i[14:0];
        prtm_pkg::CFG_VOLTAGE_JUMP: volt_jump_q <= cfg_wdata_i[14:0];
        prtm_pkg::CFG_CURRENT_JUMP: curr_jump_q <= cfg_wdata_i;
        prtm_pkg::CFG_FAILURE_LIM:  fail_lim_q  <= cfg_wdata_i;
        prtm_pkg::CFG_CHECK_PERIOD: period_q    <= cfg_wdata_i;
        prtm_pkg::CFG_EXPECTED_CFG: exp_cfg_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: input register and result register
  logic              in_valid_q, out_valid_q;
  prtm_pkg::sample_t in_q;
  prtm_pkg::result_t out_q, out_d;
  logic              out_load, in_adv, in_take;

  assign out_load = !out_valid_q || result_o.ready;
  assign in_adv   = in_valid_q && out_load;
  assign in_take  = sample_i.valid && sample_i.ready;
  assign sample_i.ready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        in_valid_q <= sample_i.valid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Capture sample payload on transfer
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.bus_voltage_reg <= sample_i.bus_voltage_reg;
      in_q.current_count   <= sample_i.current_count;
      in_q.config_readback <= sample_i.config_readback;
    end
  end

  // Monitor state
  logic [14:0]        last_volt_q, last_volt_d;
  logic signed [15:0] last_curr_q, last_curr_d;
  logic               have_prev_q, have_prev_d;
  logic [15:0]        phase_q, phase_d;
  logic [31:0]        reads_q, reads_d;
  logic [15:0]        fails_q, fails_d;
  logic               tamper_q, tamper_d;
  logic               safe_q, safe_d;

  // Check pass
  logic [14:0]        volt;
  logic [14:0]        volt_diff;
  logic signed [16:0] curr_diff;
  logic [16:0]        curr_abs;
  logic [16:0]        phase_inc;
  logic [15:0]        period;
  logic               mismatch;
  prtm_pkg::reason_e  reason;

  always_comb begin
    volt      = {in_q.bus_voltage_reg[15:3], 2'b00};
    volt_diff = (volt >= last_volt_q) ? (volt - last_volt_q) : (last_volt_q - volt);
    curr_diff = 17'(in_q.current_count) - 17'(last_curr_q);
    curr_abs  = curr_diff[16] ? 17'(-curr_diff) : 17'(curr_diff);
    mismatch  = (phase_q == 16'd0) && (in_q.config_readback != exp_cfg_q);
    period    = (period_q == 16'd0) ? 16'd1 : period_q;
    phase_inc = {1'b0, phase_q} + 17'd1;

    // Checks in priority order
    if (volt < volt_min_q || volt > volt_max_q) begin
      reason = prtm_pkg::REASON_VOLT_WINDOW;
    end else if (in_q.current_count[15] || in_q.current_count[14:0] > curr_lim_q) begin
      reason = prtm_pkg::REASON_CURR_RANGE;
    end else if (have_prev_q && volt_diff > volt_jump_q) begin
      reason = prtm_pkg::REASON_VOLT_JUMP;
    end else if (have_prev_q && curr_abs > {1'b0, curr_jump_q}) begin
      reason = prtm_pkg::REASON_CURR_JUMP;
    end else begin
      reason = prtm_pkg::REASON_NONE;
    end

    // Hold state by default
    last_volt_d = last_volt_q;
    last_curr_d = last_curr_q;
    have_prev_d = have_prev_q;
    phase_d     = phase_q;
    reads_d     = reads_q;
    fails_d     = fails_q;
    tamper_d    = tamper_q || mismatch;
    safe_d      = safe_q;

    if (reason != prtm_pkg::REASON_NONE) begin
      tamper_d = 1'b1;
      if (fails_q != prtm_pkg::FailCountMax) begin
        fails_d = fails_q + 16'd1;
      end
      if (fails_d >= fail_lim_q) begin
        safe_d = 1'b1;
      end
    end else begin
      fails_d     = 16'd0;
      last_volt_d = volt;
      last_curr_d = in_q.current_count;
      have_prev_d = 1'b1;
      reads_d     = reads_q + 32'd1;
      phase_d     = (phase_inc >= {1'b0, period}) ? 16'd0 : phase_inc[15:0];
    end

    out_d.accepted        = (reason == prtm_pkg::REASON_NONE);
    out_d.fail_reason     = reason;
    out_d.config_mismatch = mismatch;
    out_d.tampered        = tamper_d;
    out_d.lockout         = safe_d;
    out_d.failure_count   = fails_d;
    out_d.accepted_reads  = reads_d;
    out_d.bus_voltage_mv  = volt;
    out_d.current_out     = in_q.current_count;
  end

  // Advance state when the checked sample moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_volt_q <= '0;
      last_curr_q <= '0;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      reads_q     <= '0;
      fails_q     <= '0;
      tamper_q    <= 1'b0;
      safe_q      <= 1'b0;
    end else if (in_adv) begin
      last_volt_q <= last_volt_d;
      last_curr_q <= last_curr_d;
      have_prev_q <= have_prev_d;
      phase_q     <= phase_d;
      reads_q     <= reads_d;
      fails_q     <= fails_d;
      tamper_q    <= tamper_d;
      safe_q      <= safe_d;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.accepted        = out_q.accepted;
  assign result_o.fail_reason     = out_q.fail_reason;
  assign result_o.config_mismatch = out_q.config_mismatch;
  assign result_o.tampered        = out_q.tampered;
  assign result_o.lockout         = out_q.lockout;
  assign result_o.failure_count   = out_q.failure_count;
  assign result_o.accepted_reads  = out_q.accepted_reads;
  assign result_o.bus_voltage_mv  = out_q.bus_voltage_mv;
  assign result_o.current_out     = out_q.current_out;

  // Tamper and safe-mode flags never clear once set
  a_sticky_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tamper_q || safe_q) |=> (!$past(tamper_q) || tamper_q) && (!$past(safe_q) || safe_q))
    else $error("sticky flag cleared");

  // An accepted result reports no reason and a cleared failure count
  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.accepted) |->
      (result_o.fail_reason == prtm_pkg::REASON_NONE && result_o.failure_count == 16'd0))
    else $error("accepted result carries failure info");

  // A reported mismatch always shows the tamper flag
  a_mismatch_tamper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.config_mismatch) |-> result_o.tampered)
    else $error("mismatch without tamper flag");

  // A new sample never overwrites one that cannot move on
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!in_valid_q || in_adv))
    else $error("input register overrun");

endmodule
